// ===== src/isfp_pkg.sv =====
`timescale 1ns / 1ps

package isfp_pkg;

  localparam int unsigned FRAME_LEN = 11;
  localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_ANG = 8'h53;

  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_ANG = 2'd1;
  localparam logic [1:0] KIND_GYR = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic REG_ANGLE_TIMEOUT = 1'b0;
  localparam logic REG_ACCEL_TIMEOUT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One completed frame, handed from the byte collector to the decoder.
  typedef struct packed {
    logic [7:0]         frame_type;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
    logic signed [15:0] word_t;
    logic               sum_ok;
    logic [31:0]        time_ms;
  } frame_evt_t;

  typedef struct packed {
    logic [15:0] angle_timeout_ms;
    logic [15:0] accel_timeout_ms;
  } timeouts_t;

  typedef struct packed {
    logic [1:0]         frame_kind;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic signed [15:0] temperature_raw;
    logic [15:0]        checksum_error_count;
    logic [15:0]        kind_frame_count;
    logic               angle_fresh;
    logic               accel_fresh;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    sat_inc = (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

endpackage

// ===== src/isfp_front.sv =====
`timescale 1ns / 1ps

module isfp_front
  import isfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic [31:0] time_ms,
  output logic       push,
  output frame_evt_t push_evt,
  input  logic       q_full
);

  logic [3:0] pos;
  logic [7:0] running_sum;
  logic [7:0] store [1:FRAME_LEN-2];
  logic       take;

  // only the checksum byte needs queue space
  assign in_ready = (pos != LAST_POS) || !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && (pos == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= '0;
    end else if (take) begin
      if (pos == 4'd0) begin
        if (rx_byte == HDR_BYTE) begin
          pos         <= 4'd1;
          running_sum <= rx_byte;
        end
      end else if (pos == LAST_POS) begin
        pos <= '0;
      end else begin
        pos         <= pos + 4'd1;
        running_sum <= running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (pos != 4'd0) && (pos != LAST_POS)) begin
      store[pos] <= rx_byte;
    end
  end

  always_comb begin
    push_evt.frame_type = store[1];
    push_evt.word_x     = {store[3], store[2]};
    push_evt.word_y     = {store[5], store[4]};
    push_evt.word_z     = {store[7], store[6]};
    push_evt.word_t     = {store[9], store[8]};
    push_evt.sum_ok     = (rx_byte == running_sum);
    push_evt.time_ms    = time_ms;
  end

endmodule

// ===== src/isfp_queue.sv =====
`timescale 1ns / 1ps

module isfp_queue
  import isfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_evt_t push_evt,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output frame_evt_t head_evt
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_evt_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_evt   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

endmodule

// ===== src/isfp_back.sv =====
`timescale 1ns / 1ps

module isfp_back
  import isfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  timeouts_t  timeouts,
  input  logic       head_valid,
  input  frame_evt_t head_evt,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    res
);

  logic [15:0] bad_sum_count;
  logic [15:0] accel_count;
  logic [15:0] angle_count;
  logic [15:0] gyro_count;
  logic [31:0] last_accel_time;
  logic [31:0] last_angle_time;
  logic        accel_seen;
  logic        angle_seen;

  logic [15:0] bad_sum_count_next;
  logic [15:0] accel_count_next;
  logic [15:0] angle_count_next;
  logic [15:0] gyro_count_next;
  logic [31:0] last_accel_time_next;
  logic [31:0] last_angle_time_next;
  logic        accel_seen_next;
  logic        angle_seen_next;

  logic        is_acc, is_ang, is_gyr, has_result;
  logic [31:0] angle_age, accel_age;
  result_t     res_next;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    is_acc     = head_evt.sum_ok && (head_evt.frame_type == TYPE_ACC);
    is_ang     = head_evt.sum_ok && (head_evt.frame_type == TYPE_ANG);
    is_gyr     = head_evt.sum_ok && (head_evt.frame_type == TYPE_GYR);
    has_result = !head_evt.sum_ok || is_acc || is_ang || is_gyr;

    bad_sum_count_next   = head_evt.sum_ok ? bad_sum_count : sat_inc(bad_sum_count);
    accel_count_next     = is_acc ? sat_inc(accel_count) : accel_count;
    angle_count_next     = is_ang ? sat_inc(angle_count) : angle_count;
    gyro_count_next      = is_gyr ? sat_inc(gyro_count) : gyro_count;
    last_accel_time_next = is_acc ? head_evt.time_ms : last_accel_time;
    last_angle_time_next = is_ang ? head_evt.time_ms : last_angle_time;
    accel_seen_next      = accel_seen || is_acc;
    angle_seen_next      = angle_seen || is_ang;

    // ages wrap modulo 2^32, judged after this frame's stamp
    angle_age = head_evt.time_ms - last_angle_time_next;
    accel_age = head_evt.time_ms - last_accel_time_next;

    res_next.checksum_error_count = bad_sum_count_next;
    res_next.angle_fresh = angle_seen_next && (angle_age <= {16'd0, timeouts.angle_timeout_ms});
    res_next.accel_fresh = accel_seen_next && (accel_age <= {16'd0, timeouts.accel_timeout_ms});
    res_next.value_x         = head_evt.word_x;
    res_next.value_y         = head_evt.word_y;
    res_next.value_z         = head_evt.word_z;
    res_next.temperature_raw = is_acc ? head_evt.word_t : 16'sd0;
    if (!head_evt.sum_ok) begin
      res_next.frame_kind       = KIND_BAD;
      res_next.kind_frame_count = '0;
      res_next.value_x          = 16'sd0;
      res_next.value_y          = 16'sd0;
      res_next.value_z          = 16'sd0;
    end else if (is_acc) begin
      res_next.frame_kind       = KIND_ACC;
      res_next.kind_frame_count = accel_count_next;
    end else if (is_ang) begin
      res_next.frame_kind       = KIND_ANG;
      res_next.kind_frame_count = angle_count_next;
    end else begin
      res_next.frame_kind       = KIND_GYR;
      res_next.kind_frame_count = gyro_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_sum_count   <= '0;
      accel_count     <= '0;
      angle_count     <= '0;
      gyro_count      <= '0;
      last_accel_time <= '0;
      last_angle_time <= '0;
      accel_seen      <= 1'b0;
      angle_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        bad_sum_count   <= bad_sum_count_next;
        accel_count     <= accel_count_next;
        angle_count     <= angle_count_next;
        gyro_count      <= gyro_count_next;
        last_accel_time <= last_accel_time_next;
        last_angle_time <= last_angle_time_next;
        accel_seen      <= accel_seen_next;
        angle_seen      <= angle_seen_next;
      end
      if (pop && has_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/imu_serial_frame_parser.sv =====
`timescale 1ns / 1ps
// Byte-serial parser for 11-byte IMU frames (header 0x55, type, four
// little-endian words, 8-bit sum).
// Input channel: in_valid/in_ready with rx_byte and the current time_ms. One
//   item per byte; one byte per cycle, back to back, while in_ready is high.
// Output channel: out_valid/out_ready. A result appears only for the byte
//   that ends a frame: kind 0/1/2 for accel/angle/gyro, 3 for a bad sum.
//   Unknown frame types with a good sum give nothing.
// Path: the closing byte's frame is written into the queue, then the decoder
//   pops it and registers the result, raising out_valid. The decoder retires
//   one frame per cycle unless the output is stalled.
// A small frame queue sits between collector and decoder, so a stalled
//   receiver only holds in_ready low on a closing byte once the queue and
//   output register are both full; other bytes keep flowing.
// Reset (rst, synchronous): hunting for a header, counters and timestamps
//   cleared, timeouts back to 100 ms, queue and output empty.
// APB: reg 0 at 0x0 angle timeout, reg 1 at 0x4 accel timeout (16 bit).
// QUEUE_DEPTH: 2 or more.
module imu_serial_frame_parser
  import isfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // byte stream in
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic [31:0]        time_ms,
  // results out
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_kind,
  output logic signed [15:0] value_x,
  output logic signed [15:0] value_y,
  output logic signed [15:0] value_z,
  output logic signed [15:0] temperature_raw,
  output logic [15:0]        checksum_error_count,
  output logic [15:0]        kind_frame_count,
  output logic               angle_fresh,
  output logic               accel_fresh,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  timeouts_t  timeouts;
  logic       cfg_wr;
  logic       q_push, q_full, q_pop, q_head_valid;
  frame_evt_t q_push_evt, q_head_evt;
  result_t    res;

  // --- configuration registers -----------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeouts.angle_timeout_ms <= TIMEOUT_RESET;
      timeouts.accel_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ANGLE_TIMEOUT: timeouts.angle_timeout_ms <= pwdata[15:0];
        REG_ACCEL_TIMEOUT: timeouts.accel_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ANGLE_TIMEOUT: prdata = {16'd0, timeouts.angle_timeout_ms};
      REG_ACCEL_TIMEOUT: prdata = {16'd0, timeouts.accel_timeout_ms};
      default:           prdata = '0;
    endcase
  end

  // --- front: header hunt, byte collection, running sum ----------------
  isfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .time_ms  (time_ms),
    .push     (q_push),
    .push_evt (q_push_evt),
    .q_full   (q_full)
  );

  // --- completed-frame queue -------------------------------------------
  isfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_evt   (q_push_evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_evt   (q_head_evt)
  );

  // --- back: decode, counters, freshness, output register --------------
  isfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .timeouts   (timeouts),
    .head_valid (q_head_valid),
    .head_evt   (q_head_evt),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign frame_kind           = res.frame_kind;
  assign value_x              = res.value_x;
  assign value_y              = res.value_y;
  assign value_z              = res.value_z;
  assign temperature_raw      = res.temperature_raw;
  assign checksum_error_count = res.checksum_error_count;
  assign kind_frame_count     = res.kind_frame_count;
  assign angle_fresh          = res.angle_fresh;
  assign accel_fresh          = res.accel_fresh;

  // --- checks ----------------------------------------------------------
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("frame pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("frame popped from an empty queue");

  a_bad_sum_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == KIND_BAD) |->
      (value_x == 16'sd0 && kind_frame_count == 16'd0 && checksum_error_count != 16'd0))
    else $error("checksum error result carries data");

  a_temp_only_accel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind != KIND_ACC) |-> (temperature_raw == 16'sd0))
    else $error("temperature on a non-accel result");

endmodule
